[hdl/dcbhp_pkg.sv]
`default_nettype none

package dcbhp_pkg;

  // Field and datapath widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned AlphaW  = 15;
  localparam int unsigned CountW  = 16;
  localparam int unsigned FracW   = 15;
  localparam int unsigned HistW   = 34;
  localparam int unsigned DeltaW  = SampleW + 1;
  localparam int unsigned SumW    = HistW + 1;
  localparam int unsigned ProdW   = SumW + AlphaW + 1;
  localparam int unsigned QuotW   = HistW + 1 - FracW;

  // Reset coefficient, about 100 Hz at 16 kHz
  localparam logic [AlphaW-1:0] AlphaReset = 15'd31506;

  // Rounding offsets for the Q15 product
  localparam logic signed [ProdW-1:0] RoundPos = ProdW'(16384);
  localparam logic signed [ProdW-1:0] RoundNeg = ProdW'(16383);
  localparam logic signed [SumW-1:0]  TruncNeg = SumW'(32767);

  // Saturation limits
  localparam logic signed [QuotW-1:0] SatMax = QuotW'(32767);
  localparam logic signed [QuotW-1:0] SatMin = -QuotW'(32768);
  localparam logic [CountW-1:0]       CountMax = '1;

  // Input word held in the input register
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      enable;
    logic                      last;
  } in_word_t;

endpackage

`default_nettype wire

[hdl/dc_blocking_highpass_q15_unit.sv]
`default_nettype none

// One-pole DC-blocking high-pass filter, y = alpha*(x - x_prev + y_prev) with a
// 34-bit Q15 history, one 16-bit sample in and one result out per clock while
// out_stall_i does not hold the result register. Throughput is one word per cycle
// under the same condition. A word loads into the input register when it is
// accepted and into the result register when it advances. The recurrence
// closes combinationally through one 35x16 multiplier followed by the rounding add,
// the truncating add and the saturation compare. The first enabled word after
// reset or a disabled word seeds the previous input; a disabled word passes
// through and clears the history and the clip count. clip_count is final on the
// word flagged block_end. The user must write alpha_q15 through cfg_we_i/cfg_wdata_i
// only while the stream is idle; the block itself does not enforce this.
module dc_blocking_highpass_q15_unit (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  // configuration
  input  wire                                    cfg_we_i,
  input  wire        [dcbhp_pkg::AlphaW-1:0]     cfg_wdata_i,
  // input channel
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire signed [dcbhp_pkg::SampleW-1:0]    sample_in_i,
  input  wire                                    enable_i,
  input  wire                                    block_last_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic signed [dcbhp_pkg::SampleW-1:0]   sample_out_o,
  output logic                                   clipped_o,
  output logic       [dcbhp_pkg::CountW-1:0]     clip_count_o,
  output logic                                   block_end_o
);

  import dcbhp_pkg::*;

  logic [AlphaW-1:0] alpha_q;

  logic     s1_valid_q;
  in_word_t s1_q;

  logic signed [SampleW-1:0] last_in_q, last_in_d;
  logic signed [HistW-1:0]   hist_q, hist_d;
  logic                      seeded_q, seeded_d;
  logic [CountW-1:0]         clips_q, clips_d;

  logic signed [SampleW-1:0] sample_d;
  logic                      clipped_d;
  logic [CountW-1:0]         count_d;

  logic out_free;
  logic s1_adv;
  logic in_acc;

  logic signed [SampleW-1:0] prev;
  logic signed [DeltaW-1:0]  delta;
  logic signed [SumW-1:0]    acc_sum;
  logic signed [ProdW-1:0]   prod;
  logic signed [ProdW-1:0]   rnd;
  logic signed [HistW-1:0]   y;
  logic signed [SumW-1:0]    trunc;
  logic signed [QuotW-1:0]   quot;
  logic [CountW-1:0]         count_inc;

  // Handshake: output register frees when empty or taken
  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Coefficient register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaReset;
    end else if (cfg_we_i) begin
      alpha_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.sample <= sample_in_i;
      s1_q.enable <= enable_i;
      s1_q.last   <= block_last_i;
    end
  end

  // Filter datapath: difference, Q15 accumulate, multiply, round and truncate
  always_comb begin
    prev    = seeded_q ? last_in_q : s1_q.sample;
    delta   = DeltaW'(s1_q.sample) - DeltaW'(prev);
    acc_sum = SumW'($signed({delta, {FracW{1'b0}}})) + SumW'(hist_q);
    prod    = ProdW'(acc_sum) * $signed(ProdW'({1'b0, alpha_q}));
    // round half away from zero, then divide by 2^15
    rnd     = prod + (prod[ProdW-1] ? RoundNeg : RoundPos);
    y       = rnd[FracW+HistW-1:FracW];
    // truncate toward zero to the sample scale
    trunc   = SumW'(y) + (y[HistW-1] ? TruncNeg : '0);
    quot    = trunc[SumW-1:FracW];
  end

  // Saturation, clip count and next state
  always_comb begin
    sample_d  = quot[SampleW-1:0];
    clipped_d = 1'b0;
    if (quot > SatMax) begin
      sample_d  = SatMax[SampleW-1:0];
      clipped_d = 1'b1;
    end else if (quot < SatMin) begin
      sample_d  = SatMin[SampleW-1:0];
      clipped_d = 1'b1;
    end

    count_inc = (clipped_d && clips_q != CountMax) ? clips_q + 1'b1 : clips_q;

    if (s1_q.enable) begin
      count_d   = count_inc;
      last_in_d = s1_q.sample;
      hist_d    = y;
      seeded_d  = 1'b1;
      clips_d   = s1_q.last ? '0 : count_inc;
    end else begin
      sample_d  = s1_q.sample;
      clipped_d = 1'b0;
      count_d   = '0;
      last_in_d = '0;
      hist_d    = '0;
      seeded_d  = 1'b0;
      clips_d   = '0;
    end
  end

  // Filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_in_q <= '0;
      hist_q    <= '0;
      seeded_q  <= 1'b0;
      clips_q   <= '0;
    end else if (s1_adv) begin
      last_in_q <= last_in_d;
      hist_q    <= hist_d;
      seeded_q  <= seeded_d;
      clips_q   <= clips_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_adv) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      sample_out_o <= sample_d;
      clipped_o    <= clipped_d;
      clip_count_o <= count_d;
      block_end_o  <= s1_q.last;
    end
  end

`ifndef SYNTHESIS
  // an empty input register never stalls the source
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  // a saturated word sits at a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (sample_out_o == SatMax[SampleW-1:0] || sample_out_o == SatMin[SampleW-1:0]))
    else $error("clipped word not at a rail");

  // a clipped word is counted
  a_clip_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |-> (clip_count_o != '0))
    else $error("clipped word with zero clip count");

  // block end restarts the clip count
  a_block_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_q.last) |=> (clips_q == '0))
    else $error("clip count not cleared after block end");

  // disabled word clears history
  a_disable_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_q.enable) |=> (!seeded_q && hist_q == '0))
    else $error("history not cleared by disabled word");
`endif

endmodule

`default_nettype wire

[sim/dc_blocking_highpass_q15_check.sv]
// Watches both channels of the DC blocker, predicts every output word from the
// accepted input words and the coefficient writes, and compares field by field.
module dc_blocking_highpass_q15_check (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire        [dcbhp_pkg::AlphaW-1:0]  cfg_wdata_i,
  input  wire                                 in_valid_i,
  input  wire                                 in_stall_i,
  input  wire signed [dcbhp_pkg::SampleW-1:0] sample_in_i,
  input  wire                                 enable_i,
  input  wire                                 block_last_i,
  input  wire                                 out_valid_i,
  input  wire                                 out_stall_i,
  input  wire signed [dcbhp_pkg::SampleW-1:0] sample_out_i,
  input  wire                                 clipped_i,
  input  wire        [dcbhp_pkg::CountW-1:0]  clip_count_i,
  input  wire                                 block_end_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  import dcbhp_pkg::*;

  localparam longint QOne     = longint'(1) << FracW;
  localparam longint QHalf    = QOne / 2;
  localparam longint LevelMax = 32767;
  localparam longint LevelMin = -32768;

  typedef struct packed {
    logic signed [SampleW-1:0] level;
    logic                      clip;
    logic [CountW-1:0]         count;
    logic                      last;
  } filt_word_t;

  filt_word_t                expected_q[$];
  logic [AlphaW-1:0]         alpha;
  logic signed [SampleW-1:0] prev_x;
  logic signed [HistW-1:0]   hist_q15;
  logic                      seeded;
  logic [CountW-1:0]         block_clips;
  int                        words_seen;

  // One line per mismatch, and a count
  task automatic report_mismatch(input string what, input longint got, input longint want);
    fail_count_o++;
    $display("[%0t] output word %0d: %s got %0d, expected %0d",
             $time, words_seen, what, got, want);
  endtask

  task automatic clear_filter_state();
    prev_x      = '0;
    hist_q15    = '0;
    seeded      = 1'b0;
    block_clips = '0;
  endtask

  // Run one input word through the filter and queue the output word it yields
  task automatic filter_word(input logic signed [SampleW-1:0] x, input logic en,
                             input logic last);
    longint     prod;
    longint     yq;
    longint     level;
    filt_word_t r;
    r.last = last;
    if (!en) begin
      // bypass: word passes unchanged, history and clip count clear
      clear_filter_state();
      r.level = x;
      r.clip  = 1'b0;
      r.count = '0;
    end else begin
      // first word after reset or bypass seeds the previous input
      if (!seeded) begin
        prev_x = x;
        seeded = 1'b1;
      end
      prod = ((longint'(x) - longint'(prev_x)) * QOne + longint'(hist_q15)) * longint'(alpha);
      // divide by 2^15, rounding half away from zero
      yq = (prod >= 0) ? (prod + QHalf) / QOne : (prod - QHalf) / QOne;
      hist_q15 = yq[HistW-1:0];
      prev_x   = x;
      // output truncates toward zero, then saturates
      level  = longint'(hist_q15) / QOne;
      r.clip = 1'b0;
      if (level > LevelMax) begin
        level  = LevelMax;
        r.clip = 1'b1;
      end else if (level < LevelMin) begin
        level  = LevelMin;
        r.clip = 1'b1;
      end
      if (r.clip && block_clips != '1) block_clips++;
      r.level = level[SampleW-1:0];
      r.count = block_clips;
      if (last) block_clips = '0;
    end
    expected_q.push_back(r);
  endtask

  // Compare before predicting; each word passes the input and result registers first
  always @(posedge clk_i or negedge rst_ni) begin
    filt_word_t want;
    if (!rst_ni) begin
      alpha = AlphaReset;
      clear_filter_state();
      expected_q.delete();
      fail_count_o = 0;
      words_seen   = 0;
    end else begin
      if (cfg_we_i) alpha = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        words_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word, sample_out", sample_out_i, 0);
        end else begin
          want = expected_q.pop_front();
          if (sample_out_i !== want.level) report_mismatch("sample_out", sample_out_i, want.level);
          if (clipped_i !== want.clip) report_mismatch("clipped", clipped_i, want.clip);
          if (clip_count_i !== want.count) report_mismatch("clip_count", clip_count_i, want.count);
          if (block_end_i !== want.last) report_mismatch("block_end", block_end_i, want.last);
        end
      end
      if (in_valid_i && !in_stall_i) filter_word(sample_in_i, enable_i, block_last_i);
    end
    pending_o = expected_q.size();
  end

endmodule

[sim/dc_blocking_highpass_q15_unit_test.sv]
// Stimulus and verdict for the DC blocker; prediction lives in the checker.
module dc_blocking_highpass_q15_unit_test;
  import dcbhp_pkg::*;

  localparam int CycleLimit    = 200_000;
  localparam int PhaseWords    = 200;
  localparam int PhaseCount    = 8;
  localparam int SatWords      = 64;
  localparam int SatHalfPeriod = 18;

  localparam logic signed [SampleW-1:0] LevelHi = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] LevelLo = 16'sh8000;
  localparam logic [AlphaW-1:0] AlphaPicks [5] = '{AlphaReset, 15'd0, 15'h7FFF, 15'd1, 15'd16384};

  typedef enum logic [1:0] {RxFree, RxLight, RxHeavy, RxPeriodic} rx_mode_e;
  typedef enum logic [2:0] {ShapeNoise, ShapeDc, ShapeSquare, ShapeRamp, ShapeHold} shape_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      cfg_we     = 1'b0;
  logic        [AlphaW-1:0]  cfg_wdata  = '0;
  logic                      in_valid   = 1'b0;
  wire                       in_stall;
  logic signed [SampleW-1:0] sample_in  = '0;
  logic                      enable     = 1'b0;
  logic                      block_last = 1'b0;
  wire                       out_valid;
  logic                      out_stall  = 1'b0;
  wire signed  [SampleW-1:0] sample_out;
  wire                       clipped;
  wire         [CountW-1:0]  clip_count;
  wire                       block_end;

  int          fail_count;
  int          pending;
  int unsigned cycles     = 0;
  int          burst_left = 0;
  logic        rx_quiet   = 1'b0;
  rx_mode_e    rx_mode    = RxFree;
  int          rx_timer   = 0;
  int          stall_run  = 0;

  // per-block waveform parameters
  shape_e                    shape       = ShapeNoise;
  logic signed [SampleW-1:0] base_level  = '0;
  int                        ramp_step   = 0;
  int                        square_half = 1;

  always #2 clk_i = ~clk_i;

  dc_blocking_highpass_q15_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_in_i  (sample_in),
    .enable_i     (enable),
    .block_last_i (block_last),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sample_out_o (sample_out),
    .clipped_o    (clipped),
    .clip_count_o (clip_count),
    .block_end_o  (block_end)
  );

  dc_blocking_highpass_q15_check filt_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .sample_in_i  (sample_in),
    .enable_i     (enable),
    .block_last_i (block_last),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .sample_out_i (sample_out),
    .clipped_i    (clipped),
    .clip_count_i (clip_count),
    .block_end_i  (block_end),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver stall: random mode, redrawn when its timer runs out, stall runs capped
  always @(negedge clk_i) begin
    logic stall_next;
    stall_next = 1'b0;
    if (rst_ni && !rx_quiet) begin
      if (rx_timer == 0) begin
        rx_mode  = rx_mode_e'($urandom_range(0, 3));
        rx_timer = $urandom_range(16, 96);
      end
      rx_timer--;
      case (rx_mode)
        RxLight:    stall_next = ($urandom_range(0, 3) == 0);
        RxHeavy:    stall_next = ($urandom_range(0, 4) != 0);
        RxPeriodic: stall_next = (rx_timer % 4 != 0);
        default:    stall_next = 1'b0;
      endcase
      if (stall_run >= 6) stall_next = 1'b0;
    end
    stall_run = stall_next ? stall_run + 1 : 0;
    out_stall <= stall_next;
  end

  // Present one word at the falling edge, return at the edge that takes it
  task automatic send_word(input logic signed [SampleW-1:0] x, input logic en,
                           input logic last);
    @(negedge clk_i);
    in_valid   <= 1'b1;
    sample_in  <= x;
    enable     <= en;
    block_last <= last;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic hold_off(input int n);
    @(negedge clk_i);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Bursts of random length with random gaps, sometimes back to back
  task automatic send_paced(input logic signed [SampleW-1:0] x, input logic en,
                            input logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 10));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_word(x, en, last);
  endtask

  // Stop sending until every expected word has come, plus pipeline slack
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_alpha(input logic [AlphaW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [SampleW-1:0] shaped_level(input int i);
    int v;
    case (shape)
      ShapeNoise:  return 16'($urandom);
      ShapeDc: begin
        // offset plus small noise, clamped to the sample range
        v = int'(base_level) + int'($urandom_range(0, 64)) - 32;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
      end
      ShapeSquare: return ((i / square_half) % 2) ? base_level : ~base_level;
      ShapeRamp:   return 16'(int'(base_level) + i * ramp_step);
      default:     return base_level;
    endcase
  endfunction

  // Blocks of random shape and length, a few bypassed words, random drains
  task automatic run_phase(input int n_words, input bit drain_midway);
    int   sent;
    int   blk_len;
    int   i;
    logic en;
    logic last;
    sent = 0;
    while (sent < n_words) begin
      blk_len     = $urandom_range(1, 64);
      shape       = shape_e'($urandom_range(0, 4));
      base_level  = ($urandom_range(0, 3) == 0) ?
                    (($urandom_range(0, 1) == 1) ? LevelHi : LevelLo) : 16'($urandom);
      ramp_step   = int'($urandom_range(0, 2048)) - 1024;
      square_half = $urandom_range(1, 24);
      for (i = 0; i < blk_len && sent < n_words; i++) begin
        en   = ($urandom_range(0, 39) != 0);
        last = (i == blk_len - 1) || ($urandom_range(0, 63) == 0);
        send_paced(shaped_level(i), en, last);
        sent++;
        if ((drain_midway && sent == n_words / 2) || $urandom_range(0, 299) == 0) drain();
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_paced(16'($urandom), 1'b0, 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int p;
    int i;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset coefficient: seed, full-scale steps, bypass, reseed
    send_paced(LevelLo, 1'b1, 1'b0);
    send_paced(LevelHi, 1'b1, 1'b0);
    send_paced(LevelHi, 1'b1, 1'b0);
    send_paced(LevelHi, 1'b1, 1'b0);
    send_paced(LevelLo, 1'b1, 1'b0);
    send_paced(16'sd0, 1'b1, 1'b1);
    send_paced(LevelHi, 1'b0, 1'b0);
    send_paced(LevelLo, 1'b0, 1'b0);
    send_paced(16'sd0, 1'b0, 1'b1);
    send_paced(16'sd1000, 1'b1, 1'b0);
    send_paced(16'sd1001, 1'b1, 1'b0);
    send_paced(16'sd999, 1'b1, 1'b0);
    send_paced(-16'sd1, 1'b1, 1'b0);
    send_paced(16'sd0, 1'b1, 1'b1);
    // zero coefficient
    drain();
    write_alpha(15'd0);
    send_paced(LevelHi, 1'b1, 1'b0);
    send_paced(LevelLo, 1'b1, 1'b0);
    send_paced(16'sd5, 1'b1, 1'b1);
    // largest coefficient, full-scale alternation
    drain();
    write_alpha(15'h7FFF);
    send_paced(LevelLo, 1'b1, 1'b0);
    send_paced(LevelHi, 1'b1, 1'b0);
    send_paced(LevelLo, 1'b1, 1'b0);
    send_paced(LevelHi, 1'b1, 1'b0);
    send_paced(LevelLo, 1'b1, 1'b1);

    // random phases, each under its own coefficient
    for (p = 0; p < PhaseCount; p++) begin
      drain();
      write_alpha((p < 5) ? AlphaPicks[p] : AlphaW'($urandom_range(0, 32767)));
      run_phase(PhaseWords, p == 0);
    end

    // one block of full-scale square wave, back to back: many words clip
    drain();
    write_alpha(AlphaReset);
    rx_quiet = 1'b1;
    for (i = 0; i < SatWords; i++) begin
      send_word(((i / SatHalfPeriod) % 2) ? LevelHi : LevelLo, 1'b1, i == SatWords - 1);
    end
    drain();
    rx_quiet = 1'b0;
    // count restarts after the saturated block
    run_phase(40, 1'b0);

    drain();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[dc_blocking_highpass_q15_unit.f]
hdl/dcbhp_pkg.sv
hdl/dc_blocking_highpass_q15_unit.sv
sim/dc_blocking_highpass_q15_check.sv
sim/dc_blocking_highpass_q15_unit_test.sv
